// File: rtl/kdfb_pkg.sv
`default_nettype none

package kdfb_pkg;

  // build defaults
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int MAX_KEYS_DEF   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BLINK_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN_KEYS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP_HIGH   = 3'd5;

  // register reset values
  localparam logic [2:0]  BRIGHTNESS_RST   = 3'd5;
  localparam logic [7:0]  DEBOUNCE_RST     = 8'd40;
  localparam logic [63:0] KEY_MAP_LOW_RST  = 64'd3978425819141910832;
  localparam logic [63:0] KEY_MAP_HIGH_RST = 64'd5063528411713059128;

  // input kinds (tuser)
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // command bytes and event marks
  localparam logic [7:0] CMD_OFF     = 8'h80;
  localparam logic [7:0] CMD_ON_BIT  = 8'h08;
  localparam logic [7:0] RELEASE_BIT = 8'h80;
  localparam logic [3:0] MS_PER_STEP = 4'd10;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

endpackage

`default_nettype wire

// File: rtl/keypad_debounce_event_fifo_blink.sv
// Read transfer: the result is loaded in S_FIN, reached through S_POP when an event is popped.
// Tick transfer: S_UPD once per scanned key (8 or 16), S_PRS once per key that queues
//   both a release and a press, then S_FIN; the scan runs one key a cycle, save for S_PRS
//   steps, through the debounce-count memory's read port. One item is in work at a time.
// A result may wait in the output register; the next item is taken once it is queued.
// Reset (rst_n low at a clock edge): registers to defaults, counts read as zero through
//   per-key valid bits, FIFO empty, blink pending; no clearing pass.
`default_nettype none

module keypad_debounce_event_fifo_blink #(
  parameter int FIFO_DEPTH = kdfb_pkg::FIFO_DEPTH_DEF,
  parameter int MAX_KEYS   = kdfb_pkg::MAX_KEYS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // configuration write port
  input  wire                               cfg_we,
  input  wire [kdfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [kdfb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [kdfb_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] keys_down
  input  wire                               in_tuser,   // [0] action
  // result stream
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [kdfb_pkg::OUT_DATA_W-1:0]   out_tdata   // [7:0] key_code, [8] cmd_valid,
                                                        // [16:9] cmd_byte, [23:17] zero
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int KW = $clog2(MAX_KEYS);
  localparam logic [KW:0] NK8   = (KW+1)'(8);
  localparam logic [KW:0] NKMAX = (KW+1)'(MAX_KEYS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_PRS  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // configuration
  logic [7:0]  blink_rate_r;
  logic [2:0]  brightness_r;
  logic        sixteen_r;
  logic [7:0]  deb_r;
  logic [63:0] map_lo_r;
  logic [63:0] map_hi_r;

  // blink state
  logic [3:0] ms_r, ms_nxt;
  logic [7:0] per_r, per_nxt;
  logic       pend_r, pend_nxt;
  logic       ph_r, ph_nxt;
  logic       b_emit;
  logic [7:0] b_cmd;
  logic [7:0] on_cmd;
  logic [3:0] ms_dec;
  logic [7:0] per_dec;

  // sequencer
  logic [2:0]          state_r, state_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [KW-1:0]       key_inc;
  logic [MAX_KEYS-1:0] keys_r;
  logic [KW:0]         n_eff;
  logic                last_key;

  // debounce count memory
  logic [7:0]          cnt_mem [MAX_KEYS];
  logic [7:0]          cnt_rdata_r;
  logic [MAX_KEYS-1:0] cnt_vld_r;
  logic [KW-1:0]       cnt_raddr;
  logic                cnt_we;
  logic [7:0]          cnt_wdata;
  logic [7:0]          cnt_cur;
  logic [7:0]          cnt_dec;
  logic                rel_ev;
  logic                prs_ev;

  // event FIFO
  logic [7:0]    fifo_mem [FIFO_DEPTH];
  logic [7:0]    fifo_rdata_r;
  logic [AW-1:0] wr_idx_r;
  logic [AW-1:0] rd_idx_r;
  logic          fifo_full;
  logic          fifo_empty;
  logic          push_req;
  logic          push_en;
  logic [7:0]    push_code;
  logic          pop_en;

  logic [127:0] kmap;
  logic [3:0]   key4;
  logic [7:0]   key_code;

  // result
  logic [7:0] res_code_r, res_code_nxt;
  logic       res_cv_r, res_cv_nxt;
  logic [7:0] res_cmd_r, res_cmd_nxt;
  logic       out_tvalid_r;
  logic [kdfb_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic       fin_load;

  logic in_acc;
  logic tick_acc;
  logic read_acc;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    if (v == AW'(FIFO_DEPTH - 1)) r = '0;
    else r = v + 1'b1;
    return r;
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign tick_acc   = in_acc && (in_tuser == kdfb_pkg::ACT_TICK);
  assign read_acc   = in_acc && (in_tuser == kdfb_pkg::ACT_READ);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign fifo_empty = (rd_idx_r == wr_idx_r);
  assign fifo_full  = (idx_inc(wr_idx_r) == rd_idx_r);
  assign push_en    = push_req && !fifo_full;
  assign pop_en     = read_acc && !fifo_empty;

  assign n_eff    = sixteen_r ? NKMAX : NK8;
  assign last_key = ({1'b0, key_r} == (n_eff - 1'b1));
  assign key_inc  = key_r + 1'b1;

  assign kmap     = {map_hi_r, map_lo_r};
  assign key4     = 4'(key_r);
  assign key_code = kmap[{key4, 3'b000} +: 8];

  // blink step, applied on a tick transfer
  always_comb begin
    on_cmd   = kdfb_pkg::CMD_OFF | kdfb_pkg::CMD_ON_BIT | {5'b0, brightness_r};
    b_emit   = 1'b0;
    b_cmd    = 8'h00;
    ms_nxt   = ms_r;
    per_nxt  = per_r;
    pend_nxt = pend_r;
    ph_nxt   = ph_r;
    ms_dec   = ms_r - 1'b1;
    per_dec  = per_r - 1'b1;
    if (blink_rate_r == 8'd0) begin
      if (pend_r) begin
        b_emit   = 1'b1;
        b_cmd    = on_cmd;
        pend_nxt = 1'b0;
      end
    end else begin
      if (pend_r) begin
        b_emit   = 1'b1;
        b_cmd    = ph_r ? on_cmd : kdfb_pkg::CMD_OFF;
        pend_nxt = 1'b0;
      end
      if (ms_dec != 4'd0) begin
        ms_nxt = ms_dec;
      end else begin
        ms_nxt = kdfb_pkg::MS_PER_STEP;
        if (per_dec != 8'd0) begin
          per_nxt = per_dec;
        end else begin
          per_nxt  = blink_rate_r;
          pend_nxt = 1'b1;
          ph_nxt   = ~ph_r;
        end
      end
    end
  end

  // per-key debounce update
  always_comb begin
    cnt_cur   = cnt_vld_r[key_r] ? cnt_rdata_r : 8'd0;
    cnt_dec   = (cnt_cur != 8'd0) ? cnt_cur - 8'd1 : 8'd0;
    rel_ev    = (cnt_cur == 8'd1);
    prs_ev    = keys_r[key_r] && (cnt_dec == 8'd0);
    cnt_wdata = keys_r[key_r] ? deb_r : cnt_dec;
  end

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    cnt_raddr    = key_r;
    cnt_we       = 1'b0;
    push_req     = 1'b0;
    push_code    = key_code;
    res_code_nxt = res_code_r;
    res_cv_nxt   = res_cv_r;
    res_cmd_nxt  = res_cmd_r;
    fin_load     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (tick_acc) begin
          key_nxt      = '0;
          cnt_raddr    = '0;
          res_code_nxt = 8'd0;
          res_cv_nxt   = b_emit;
          res_cmd_nxt  = b_cmd;
          state_nxt    = S_UPD;
        end else if (read_acc) begin
          res_code_nxt = 8'd0;
          res_cv_nxt   = 1'b0;
          res_cmd_nxt  = 8'd0;
          state_nxt    = fifo_empty ? S_FIN : S_POP;
        end
      end
      S_UPD: begin
        cnt_we    = 1'b1;
        push_req  = rel_ev || prs_ev;
        push_code = rel_ev ? (key_code | kdfb_pkg::RELEASE_BIT) : key_code;
        if (rel_ev && prs_ev) begin
          state_nxt = S_PRS;
        end else if (last_key) begin
          state_nxt = S_FIN;
        end else begin
          key_nxt   = key_inc;
          cnt_raddr = key_inc;
        end
      end
      S_PRS: begin
        push_req = 1'b1;
        if (last_key) begin
          state_nxt = S_FIN;
        end else begin
          key_nxt   = key_inc;
          cnt_raddr = key_inc;
          state_nxt = S_UPD;
        end
      end
      S_POP: begin
        res_code_nxt = fifo_rdata_r;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          fin_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[key_r] <= cnt_wdata;
    cnt_rdata_r <= cnt_mem[cnt_raddr];
    if (push_en) fifo_mem[wr_idx_r] <= push_code;
    if (pop_en) fifo_rdata_r <= fifo_mem[rd_idx_r];
  end

  // payload
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    res_code_r <= res_code_nxt;
    res_cv_r   <= res_cv_nxt;
    res_cmd_r  <= res_cmd_nxt;
    if (tick_acc) keys_r <= in_tdata[MAX_KEYS-1:0];
    if (fin_load) begin
      out_tdata_r <= {7'd0, res_cmd_r, res_cv_r, res_code_r};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_vld_r    <= '0;
      wr_idx_r     <= '0;
      rd_idx_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cnt_we) cnt_vld_r[key_r] <= 1'b1;
      if (push_en) wr_idx_r <= idx_inc(wr_idx_r);
      if (pop_en) rd_idx_r <= idx_inc(rd_idx_r);
      if (fin_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // configuration and blink timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_rate_r <= 8'd0;
      brightness_r <= kdfb_pkg::BRIGHTNESS_RST;
      sixteen_r    <= 1'b0;
      deb_r        <= kdfb_pkg::DEBOUNCE_RST;
      map_lo_r     <= kdfb_pkg::KEY_MAP_LOW_RST;
      map_hi_r     <= kdfb_pkg::KEY_MAP_HIGH_RST;
      ms_r         <= kdfb_pkg::MS_PER_STEP;
      per_r        <= 8'd0;
      pend_r       <= 1'b1;
      ph_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kdfb_pkg::REG_BLINK_RATE:     blink_rate_r <= cfg_wdata[7:0];
          kdfb_pkg::REG_BRIGHTNESS:     brightness_r <= cfg_wdata[2:0];
          kdfb_pkg::REG_SIXTEEN_KEYS:   sixteen_r    <= cfg_wdata[0];
          kdfb_pkg::REG_DEBOUNCE_TICKS: deb_r        <= cfg_wdata[7:0];
          kdfb_pkg::REG_KEY_MAP_LOW:    map_lo_r     <= cfg_wdata;
          kdfb_pkg::REG_KEY_MAP_HIGH:   map_hi_r     <= cfg_wdata;
          default: ;
        endcase
      end
      // a rate write restarts the blink cycle in the off phase
      if (cfg_we && (cfg_index == kdfb_pkg::REG_BLINK_RATE)) begin
        per_r  <= cfg_wdata[7:0];
        ms_r   <= kdfb_pkg::MS_PER_STEP;
        pend_r <= 1'b1;
        ph_r   <= 1'b0;
      end else if (tick_acc) begin
        ms_r   <= ms_nxt;
        per_r  <= per_nxt;
        pend_r <= pend_nxt;
        ph_r   <= ph_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |-> (rd_idx_r != wr_idx_r))
    else $error("pop issued on empty FIFO");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_idx_r <= AW'(FIFO_DEPTH - 1)) && (rd_idx_r <= AW'(FIFO_DEPTH - 1)))
    else $error("FIFO index beyond depth");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPD) || (state_r == S_PRS)) |-> ({1'b0, key_r} < n_eff))
    else $error("scan past last key");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_tdata_r)))
    else $error("pending result changed");

  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tdata_r[8]) |-> (out_tdata_r[16:9] == 8'd0))
    else $error("command byte without command valid");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import kdfb_pkg::*;

  localparam int DEPTH       = FIFO_DEPTH_DEF;
  localparam int KEYS_BUILT  = MAX_KEYS_DEF;
  localparam int GAP_MAX     = 12;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int N_PHASES    = 11;
  localparam int PHASE_ITEMS = 150;
  localparam int N_DIR       = 27;

  // same layout as out_tdata, key_code in the low byte
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] cmd;
    logic       cmd_valid;
    logic [7:0] code;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   act;
    logic [15:0]            keys;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   has_want;
    result_t                want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;   // [15:0] keys_down
  logic                   in_tuser = 1'b0; // [0] action
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;       // [7:0] key_code, [8] cmd_valid, [16:9] cmd_byte

  keypad_debounce_event_fifo_blink u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // shadow copy of registers and state
  logic [7:0]  m_blink_rate;
  logic [2:0]  m_bright;
  logic        m_sixteen;
  logic [7:0]  m_debounce;
  logic [63:0] m_map_lo;
  logic [63:0] m_map_hi;
  logic [7:0]  hold_cnt [16];
  logic [7:0]  ev_store [DEPTH];
  int          ev_rd;
  int          ev_wr;
  logic [3:0]  m_ms_left;
  logic [7:0]  blink_periods;
  logic        blink_pending;
  logic        blink_phase;

  result_t     pending_results [$];
  int          n_err = 0;
  int          idle_cycles = 0;
  bit          send_no_idle = 1'b0;
  bit          recv_no_idle = 1'b0;

  function automatic void queue_event(logic [7:0] code);
    int nxt;
    nxt = (ev_wr + 1) % DEPTH;
    if (nxt != ev_rd) begin
      ev_store[ev_wr] = code;
      ev_wr = nxt;
    end
  endfunction

  function automatic result_t predict_item(logic act, logic [15:0] keys);
    result_t r;
    int n;
    int k;
    logic [7:0] code;
    logic [7:0] on_cmd;
    r = '0;
    if (act == ACT_READ) begin
      if (ev_rd != ev_wr) begin
        r.code = ev_store[ev_rd];
        ev_rd = (ev_rd + 1) % DEPTH;
      end
      return r;
    end
    on_cmd = CMD_OFF | CMD_ON_BIT | {5'd0, m_bright};
    if (m_blink_rate == 8'd0) begin
      // blink off: restore normal brightness once
      if (blink_pending) begin
        blink_pending = 1'b0;
        r.cmd_valid = 1'b1;
        r.cmd = on_cmd;
      end
    end else begin
      if (blink_pending) begin
        blink_pending = 1'b0;
        r.cmd_valid = 1'b1;
        r.cmd = blink_phase ? on_cmd : CMD_OFF;
      end
      m_ms_left = m_ms_left - 4'd1;
      if (m_ms_left == 4'd0) begin
        m_ms_left = MS_PER_STEP;
        blink_periods = blink_periods - 8'd1;
        if (blink_periods == 8'd0) begin
          blink_periods = m_blink_rate;
          blink_pending = 1'b1;
          blink_phase = ~blink_phase;
        end
      end
    end
    n = m_sixteen ? 16 : 8;
    if (n > KEYS_BUILT) n = KEYS_BUILT;
    for (k = 0; k < n; k++) begin
      code = (k < 8) ? m_map_lo[8*k +: 8] : m_map_hi[8*(k-8) +: 8];
      if (hold_cnt[k] != 8'd0) begin
        hold_cnt[k] = hold_cnt[k] - 8'd1;
        if (hold_cnt[k] == 8'd0) queue_event(code | RELEASE_BIT);
      end
      if (keys[k]) begin
        if (hold_cnt[k] == 8'd0) queue_event(code);
        hold_cnt[k] = m_debounce;
      end
    end
    return r;
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLINK_RATE: begin
        m_blink_rate  = val[7:0];
        blink_periods = val[7:0];
        m_ms_left     = MS_PER_STEP;
        blink_pending = 1'b1;
        blink_phase   = 1'b0;
      end
      REG_BRIGHTNESS:     m_bright   = val[2:0];
      REG_SIXTEEN_KEYS:   m_sixteen  = val[0];
      REG_DEBOUNCE_TICKS: m_debounce = val[7:0];
      REG_KEY_MAP_LOW:    m_map_lo   = val;
      REG_KEY_MAP_HIGH:   m_map_hi   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send(input logic act, input logic [15:0] keys,
                      input logic has_want, input result_t want);
    int gap;
    result_t r;
    gap = send_no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= keys;
    do @(posedge clk); while (!in_tready);
    r = predict_item(act, keys);
    pending_results.push_back(has_want ? want : r);
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // result side: random stall before each transfer
  initial begin
    int stall;
    forever begin
      stall = recv_no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result %h, nothing outstanding", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("key_code", want.code, got.code);
        check_field("cmd_valid", {7'd0, want.cmd_valid}, {7'd0, got.cmd_valid});
        check_field("cmd_byte", want.cmd, got.cmd);
        check_field("pad bits", {1'b0, want.pad}, {1'b0, got.pad});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    row_t        dir_tab [N_DIR];
    logic [15:0] held;
    logic [15:0] keys;
    logic [7:0]  rate;
    logic [7:0]  deb;
    int          i;
    int          ph;

    m_blink_rate  = 8'd0;
    m_bright      = BRIGHTNESS_RST;
    m_sixteen     = 1'b0;
    m_debounce    = DEBOUNCE_RST;
    m_map_lo      = KEY_MAP_LOW_RST;
    m_map_hi      = KEY_MAP_HIGH_RST;
    for (i = 0; i < 16; i++) hold_cnt[i] = 8'd0;
    ev_rd         = 0;
    ev_wr         = 0;
    m_ms_left     = MS_PER_STEP;
    blink_periods = 8'd0;
    blink_pending = 1'b1;
    blink_phase   = 1'b0;

    // first tick after reset restores normal brightness; reads on empty give 0
    dir_tab[0]  = '{ROW_ITEM, ACT_TICK, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b1,
                    {7'd0, 8'h8D, 1'b1, 8'h00}};
    dir_tab[1]  = '{ROW_ITEM, ACT_READ, 16'hFFFF, REG_BLINK_RATE, 64'd0, 1'b1, '0};
    dir_tab[2]  = '{ROW_ITEM, ACT_TICK, 16'hFFFF, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[3]  = '{ROW_ITEM, ACT_READ, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[4]  = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_SIXTEEN_KEYS, 64'd1, 1'b0, '0};
    dir_tab[5]  = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_DEBOUNCE_TICKS, 64'd1, 1'b0, '0};
    // fills the event queue, the following tick drops releases
    dir_tab[6]  = '{ROW_ITEM, ACT_TICK, 16'hFFFF, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[7]  = '{ROW_ITEM, ACT_TICK, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[8]  = '{ROW_ITEM, ACT_READ, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[9]  = '{ROW_ITEM, ACT_TICK, 16'hFFFF, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    // zero reload: held key presses every tick
    dir_tab[10] = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_DEBOUNCE_TICKS, 64'd0, 1'b0, '0};
    dir_tab[11] = '{ROW_ITEM, ACT_TICK, 16'h8001, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[12] = '{ROW_ITEM, ACT_TICK, 16'h8001, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[13] = '{ROW_ITEM, ACT_READ, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[14] = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_BRIGHTNESS, 64'd7, 1'b0, '0};
    dir_tab[15] = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_BLINK_RATE, 64'd1, 1'b0, '0};
    // blink restart begins in the off phase
    dir_tab[16] = '{ROW_ITEM, ACT_TICK, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b1,
                    {7'd0, 8'h80, 1'b1, 8'h00}};
    dir_tab[17] = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_KEY_MAP_LOW, '1, 1'b0, '0};
    dir_tab[18] = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_KEY_MAP_HIGH, 64'd0, 1'b0, '0};
    dir_tab[19] = '{ROW_ITEM, ACT_TICK, 16'hFFFF, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[20] = '{ROW_ITEM, ACT_READ, 16'hFFFF, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[21] = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_BLINK_RATE, 64'd255, 1'b0, '0};
    dir_tab[22] = '{ROW_ITEM, ACT_READ, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[23] = '{ROW_ITEM, ACT_TICK, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[24] = '{ROW_CFG,  ACT_TICK, 16'h0000, REG_DEBOUNCE_TICKS, 64'd255, 1'b0, '0};
    dir_tab[25] = '{ROW_ITEM, ACT_TICK, 16'hFFFF, REG_BLINK_RATE, 64'd0, 1'b0, '0};
    dir_tab[26] = '{ROW_ITEM, ACT_READ, 16'h0000, REG_BLINK_RATE, 64'd0, 1'b0, '0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        set_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send(dir_tab[i].act, dir_tab[i].keys, dir_tab[i].has_want, dir_tab[i].want);
      end
    end

    held = 16'($urandom);
    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      send_no_idle = ($urandom_range(0, 3) == 0);
      recv_no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0: rate = 8'd0;
        1: rate = 8'd1;
        2: rate = 8'd255;
        default: rate = 8'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0: deb = 8'd1;
        1: deb = 8'd255;
        2: deb = 8'($urandom_range(1, 255));
        default: deb = 8'($urandom_range(1, 8));
      endcase
      set_reg(REG_BLINK_RATE, {56'd0, rate});
      set_reg(REG_BRIGHTNESS, 64'($urandom_range(0, 7)));
      set_reg(REG_SIXTEEN_KEYS, 64'($urandom_range(0, 1)));
      set_reg(REG_DEBOUNCE_TICKS, {56'd0, deb});
      set_reg(REG_KEY_MAP_LOW, {$urandom, $urandom});
      set_reg(REG_KEY_MAP_HIGH, {$urandom, $urandom});

      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 45) begin
          send(ACT_READ, 16'($urandom), 1'b0, '0);
        end else begin
          // mostly a slowly changing set of held keys, sometimes noise
          case ($urandom_range(0, 15))
            0: keys = 16'($urandom);
            1, 2: begin
              held = held ^ (16'd1 << $urandom_range(0, 15));
              keys = held;
            end
            3: begin
              held = '0;
              keys = held;
            end
            default: keys = held;
          endcase
          send(ACT_TICK, keys, 1'b0, '0);
        end
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
